@@ hw/rtl/rtnh_pkg.sv @@
// Shared types, constants and micro-op table for the ray/triangle nearest-hit core.
package rtnh_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int TAG_W         = 32;
  localparam int CFG_AW        = 3;
  localparam int STEP_W        = 5;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_DIR_X    = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_DIR_Y    = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_DIR_Z    = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_DET_THR  = 3'd6;

  // multiplier A operand sources
  localparam logic [3:0] SA_D0  = 4'd0;
  localparam logic [3:0] SA_D1  = 4'd1;
  localparam logic [3:0] SA_D2  = 4'd2;
  localparam logic [3:0] SA_E10 = 4'd3;
  localparam logic [3:0] SA_E11 = 4'd4;
  localparam logic [3:0] SA_E12 = 4'd5;
  localparam logic [3:0] SA_TV0 = 4'd6;
  localparam logic [3:0] SA_TV1 = 4'd7;
  localparam logic [3:0] SA_TV2 = 4'd8;
  localparam logic [3:0] SA_E20 = 4'd9;
  localparam logic [3:0] SA_E21 = 4'd10;
  localparam logic [3:0] SA_E22 = 4'd11;

  // multiplier B operand sources
  localparam logic [3:0] SB_E20 = 4'd0;
  localparam logic [3:0] SB_E21 = 4'd1;
  localparam logic [3:0] SB_E22 = 4'd2;
  localparam logic [3:0] SB_P0  = 4'd3;
  localparam logic [3:0] SB_P1  = 4'd4;
  localparam logic [3:0] SB_P2  = 4'd5;
  localparam logic [3:0] SB_E10 = 4'd6;
  localparam logic [3:0] SB_E11 = 4'd7;
  localparam logic [3:0] SB_E12 = 4'd8;
  localparam logic [3:0] SB_Q0  = 4'd9;
  localparam logic [3:0] SB_Q1  = 4'd10;
  localparam logic [3:0] SB_Q2  = 4'd11;
  localparam logic [3:0] SB_T   = 4'd12;

  // accumulator destinations
  localparam logic [3:0] DS_P0  = 4'd0;
  localparam logic [3:0] DS_P1  = 4'd1;
  localparam logic [3:0] DS_P2  = 4'd2;
  localparam logic [3:0] DS_DET = 4'd3;
  localparam logic [3:0] DS_NU  = 4'd4;
  localparam logic [3:0] DS_Q0  = 4'd5;
  localparam logic [3:0] DS_Q1  = 4'd6;
  localparam logic [3:0] DS_Q2  = 4'd7;
  localparam logic [3:0] DS_NV  = 4'd8;
  localparam logic [3:0] DS_NT  = 4'd9;
  localparam logic [3:0] DS_HX  = 4'd10;
  localparam logic [3:0] DS_HY  = 4'd11;
  localparam logic [3:0] DS_HZ  = 4'd12;

  // step ranges of the micro-op table
  localparam logic [STEP_W-1:0] STEP_MAC_END = 5'd24;
  localparam logic [STEP_W-1:0] STEP_PNT_BEG = 5'd24;
  localparam logic [STEP_W-1:0] STEP_PNT_END = 5'd27;

  typedef struct packed {
    logic       vld;
    logic       first;
    logic       last;
    logic       sub;
    logic [3:0] asel;
    logic [3:0] bsel;
    logic [3:0] dst;
  } uop_t;

  typedef struct packed {
    logic              load;
    logic              issue;
    logic [STEP_W-1:0] step;
    logic              check;
    logic              div_step;
    logic              cmp;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic miss;
    logic better;
  } sts_t;

  function automatic uop_t mk(input logic f, input logic l, input logic s,
                              input logic [3:0] a, input logic [3:0] b,
                              input logic [3:0] d);
    uop_t u;
    u.vld = 1'b1; u.first = f; u.last = l; u.sub = s;
    u.asel = a; u.bsel = b; u.dst = d;
    return u;
  endfunction

  function automatic uop_t uop(input logic [STEP_W-1:0] step);
    uop_t u;
    u = '0;
    case (step)
      5'd0:  u = mk(1'b1, 1'b0, 1'b0, SA_D1,  SB_E22, DS_P0);
      5'd1:  u = mk(1'b0, 1'b1, 1'b1, SA_D2,  SB_E21, DS_P0);
      5'd2:  u = mk(1'b1, 1'b0, 1'b0, SA_D2,  SB_E20, DS_P1);
      5'd3:  u = mk(1'b0, 1'b1, 1'b1, SA_D0,  SB_E22, DS_P1);
      5'd4:  u = mk(1'b1, 1'b0, 1'b0, SA_D0,  SB_E21, DS_P2);
      5'd5:  u = mk(1'b0, 1'b1, 1'b1, SA_D1,  SB_E20, DS_P2);
      5'd6:  u = mk(1'b1, 1'b0, 1'b0, SA_E10, SB_P0,  DS_DET);
      5'd7:  u = mk(1'b0, 1'b0, 1'b0, SA_E11, SB_P1,  DS_DET);
      5'd8:  u = mk(1'b0, 1'b1, 1'b0, SA_E12, SB_P2,  DS_DET);
      5'd9:  u = mk(1'b1, 1'b0, 1'b0, SA_TV0, SB_P0,  DS_NU);
      5'd10: u = mk(1'b0, 1'b0, 1'b0, SA_TV1, SB_P1,  DS_NU);
      5'd11: u = mk(1'b0, 1'b1, 1'b0, SA_TV2, SB_P2,  DS_NU);
      5'd12: u = mk(1'b1, 1'b0, 1'b0, SA_TV1, SB_E12, DS_Q0);
      5'd13: u = mk(1'b0, 1'b1, 1'b1, SA_TV2, SB_E11, DS_Q0);
      5'd14: u = mk(1'b1, 1'b0, 1'b0, SA_TV2, SB_E10, DS_Q1);
      5'd15: u = mk(1'b0, 1'b1, 1'b1, SA_TV0, SB_E12, DS_Q1);
      5'd16: u = mk(1'b1, 1'b0, 1'b0, SA_TV0, SB_E11, DS_Q2);
      5'd17: u = mk(1'b0, 1'b1, 1'b1, SA_TV1, SB_E10, DS_Q2);
      5'd18: u = mk(1'b1, 1'b0, 1'b0, SA_D0,  SB_Q0,  DS_NV);
      5'd19: u = mk(1'b0, 1'b0, 1'b0, SA_D1,  SB_Q1,  DS_NV);
      5'd20: u = mk(1'b0, 1'b1, 1'b0, SA_D2,  SB_Q2,  DS_NV);
      5'd21: u = mk(1'b1, 1'b0, 1'b0, SA_E20, SB_Q0,  DS_NT);
      5'd22: u = mk(1'b0, 1'b0, 1'b0, SA_E21, SB_Q1,  DS_NT);
      5'd23: u = mk(1'b0, 1'b1, 1'b0, SA_E22, SB_Q2,  DS_NT);
      5'd24: u = mk(1'b1, 1'b1, 1'b0, SA_D0,  SB_T,   DS_HX);
      5'd25: u = mk(1'b1, 1'b1, 1'b0, SA_D1,  SB_T,   DS_HY);
      5'd26: u = mk(1'b1, 1'b1, 1'b0, SA_D2,  SB_T,   DS_HZ);
      default: u = '0;
    endcase
    return u;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    r = v[31:0];
    if (v > 66'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (v < -66'sh0_8000_0000) r = 32'h8000_0000;
    return r;
  endfunction

endpackage

@@ hw/rtl/rtnh_ctrl.sv @@
// Sequencer for the ray/triangle nearest-hit core: issue, divide, compare, emit.
module rtnh_ctrl #(
  parameter int NUM_W = 48
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic            in_tlast,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  rtnh_pkg::sts_t  sts,
  output rtnh_pkg::cmd_t  cmd
);

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_PNT   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]                    state_r, state_nxt;
  logic [rtnh_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          last_r, last_nxt;
  logic                          ovld_r, ovld_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovld_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    ovld_nxt  = ovld_r && !out_tready;
    cmd       = '0;
    cmd.step  = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          last_nxt  = in_tlast;
          step_nxt  = '0;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        if (step_r == rtnh_pkg::STEP_MAC_END) begin
          state_nxt = S_CHECK;
        end else begin
          cmd.issue = 1'b1;
          step_nxt  = step_r + 1'b1;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.miss) begin
          state_nxt = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (sts.better) begin
          step_nxt  = rtnh_pkg::STEP_PNT_BEG;
          state_nxt = S_PNT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_PNT: begin
        if (step_r == rtnh_pkg::STEP_PNT_END) begin
          state_nxt = S_FIN;
        end else begin
          cmd.issue = 1'b1;
          step_nxt  = step_r + 1'b1;
        end
      end
      S_FIN: begin
        state_nxt = last_r ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!ovld_r || out_tready) begin
          cmd.emit  = 1'b1;
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      cnt_r   <= '0;
      last_r  <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

@@ hw/rtl/rtnh_dp.sv @@
// Datapath: config registers, shared multiply-accumulate, divider, best-hit state.
module rtnh_dp #(
  parameter int FRAC_BITS = 16,
  parameter int NUM_W     = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rtnh_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [31:0]                 cfg_wdata,
  input  logic [319:0]                in_tdata,
  input  rtnh_pkg::cmd_t              cmd,
  output rtnh_pkg::sts_t              sts,
  output logic [159:0]                out_tdata,
  output logic                        out_tuser
);

  logic [31:0] org_r [3];
  logic [31:0] dir_r [3];
  logic [15:0] thr_r;

  logic [31:0] e1_r [3], e2_r [3], tv_r [3];
  logic [31:0] p_r [3], q_r [3];
  logic [31:0] det_r, nu_r, nv_r, nt_r;
  logic [rtnh_pkg::TAG_W-1:0] tag_r;

  rtnh_pkg::uop_t       u, ctl_r;
  logic signed [31:0]   opa, opb;
  logic signed [63:0]   prod_r;
  logic signed [65:0]   acc_r, acc_nxt, base, term;

  logic        miss_r;
  logic [31:0] dabs_r;
  logic [31:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [32:0] rem_sh;
  logic        ge;
  logic [30:0] t_sat;
  logic        better;

  logic [31:0] best_dist_r;
  logic [rtnh_pkg::TAG_W-1:0] best_obj_r;
  logic        any_r;
  logic [31:0] best_pt_r [3];

  logic signed [33:0] dets, nus, nvs, nts;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0; org_r[1] <= '0; org_r[2] <= '0;
      dir_r[0] <= 32'h0001_0000; dir_r[1] <= '0; dir_r[2] <= '0;
      thr_r    <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        rtnh_pkg::CFG_ORIGIN_X: org_r[0] <= cfg_wdata;
        rtnh_pkg::CFG_ORIGIN_Y: org_r[1] <= cfg_wdata;
        rtnh_pkg::CFG_ORIGIN_Z: org_r[2] <= cfg_wdata;
        rtnh_pkg::CFG_DIR_X:    dir_r[0] <= cfg_wdata;
        rtnh_pkg::CFG_DIR_Y:    dir_r[1] <= cfg_wdata;
        rtnh_pkg::CFG_DIR_Z:    dir_r[2] <= cfg_wdata;
        rtnh_pkg::CFG_DET_THR:  thr_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // edge vectors at load
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= rtnh_pkg::sat32(66'($signed(in_tdata[96+32*i +: 32]))
                                 - 66'($signed(in_tdata[32*i +: 32])));
        e2_r[i] <= rtnh_pkg::sat32(66'($signed(in_tdata[192+32*i +: 32]))
                                 - 66'($signed(in_tdata[32*i +: 32])));
        tv_r[i] <= rtnh_pkg::sat32(66'($signed(org_r[i]))
                                 - 66'($signed(in_tdata[32*i +: 32])));
      end
      tag_r <= in_tdata[288 +: rtnh_pkg::TAG_W];
    end
  end

  // t saturated to 31 bits
  assign t_sat  = (|quo_r[NUM_W-1:31]) ? 31'h7FFF_FFFF : quo_r[30:0];
  assign better = ({1'b0, t_sat} < best_dist_r);

  // operand select
  always_comb begin
    u = rtnh_pkg::uop(cmd.step);
    case (u.asel)
      rtnh_pkg::SA_D0:  opa = dir_r[0];
      rtnh_pkg::SA_D1:  opa = dir_r[1];
      rtnh_pkg::SA_D2:  opa = dir_r[2];
      rtnh_pkg::SA_E10: opa = e1_r[0];
      rtnh_pkg::SA_E11: opa = e1_r[1];
      rtnh_pkg::SA_E12: opa = e1_r[2];
      rtnh_pkg::SA_TV0: opa = tv_r[0];
      rtnh_pkg::SA_TV1: opa = tv_r[1];
      rtnh_pkg::SA_TV2: opa = tv_r[2];
      rtnh_pkg::SA_E20: opa = e2_r[0];
      rtnh_pkg::SA_E21: opa = e2_r[1];
      rtnh_pkg::SA_E22: opa = e2_r[2];
      default:          opa = '0;
    endcase
    case (u.bsel)
      rtnh_pkg::SB_E20: opb = e2_r[0];
      rtnh_pkg::SB_E21: opb = e2_r[1];
      rtnh_pkg::SB_E22: opb = e2_r[2];
      rtnh_pkg::SB_P0:  opb = p_r[0];
      rtnh_pkg::SB_P1:  opb = p_r[1];
      rtnh_pkg::SB_P2:  opb = p_r[2];
      rtnh_pkg::SB_E10: opb = e1_r[0];
      rtnh_pkg::SB_E11: opb = e1_r[1];
      rtnh_pkg::SB_E12: opb = e1_r[2];
      rtnh_pkg::SB_Q0:  opb = q_r[0];
      rtnh_pkg::SB_Q1:  opb = q_r[1];
      rtnh_pkg::SB_Q2:  opb = q_r[2];
      rtnh_pkg::SB_T:   opb = {1'b0, t_sat};
      default:          opb = '0;
    endcase
  end

  // multiplier stage, floor shift folded in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= cmd.issue ? u : '0;
    end
    prod_r <= (opa * opb) >>> FRAC_BITS;
  end

  // accumulate stage
  always_comb begin
    case (ctl_r.dst)
      rtnh_pkg::DS_HX: base = 66'($signed(org_r[0]));
      rtnh_pkg::DS_HY: base = 66'($signed(org_r[1]));
      rtnh_pkg::DS_HZ: base = 66'($signed(org_r[2]));
      default:         base = '0;
    endcase
    if (!ctl_r.first) base = acc_r;
    term    = 66'(prod_r);
    acc_nxt = ctl_r.sub ? base - term : base + term;
  end

  always_ff @(posedge clk) begin
    if (ctl_r.vld) begin
      acc_r <= acc_nxt;
      if (ctl_r.last) begin
        case (ctl_r.dst)
          rtnh_pkg::DS_P0:  p_r[0] <= rtnh_pkg::sat32(acc_nxt);
          rtnh_pkg::DS_P1:  p_r[1] <= rtnh_pkg::sat32(acc_nxt);
          rtnh_pkg::DS_P2:  p_r[2] <= rtnh_pkg::sat32(acc_nxt);
          rtnh_pkg::DS_DET: det_r  <= rtnh_pkg::sat32(acc_nxt);
          rtnh_pkg::DS_NU:  nu_r   <= rtnh_pkg::sat32(acc_nxt);
          rtnh_pkg::DS_Q0:  q_r[0] <= rtnh_pkg::sat32(acc_nxt);
          rtnh_pkg::DS_Q1:  q_r[1] <= rtnh_pkg::sat32(acc_nxt);
          rtnh_pkg::DS_Q2:  q_r[2] <= rtnh_pkg::sat32(acc_nxt);
          rtnh_pkg::DS_NV:  nv_r   <= rtnh_pkg::sat32(acc_nxt);
          rtnh_pkg::DS_NT:  nt_r   <= rtnh_pkg::sat32(acc_nxt);
          rtnh_pkg::DS_HX:  best_pt_r[0] <= rtnh_pkg::sat32(acc_nxt);
          rtnh_pkg::DS_HY:  best_pt_r[1] <= rtnh_pkg::sat32(acc_nxt);
          rtnh_pkg::DS_HZ:  best_pt_r[2] <= rtnh_pkg::sat32(acc_nxt);
          default: ;
        endcase
      end
    end
  end

  // sign-normalized inside test
  always_comb begin
    dets = 34'($signed(det_r));
    nus  = 34'($signed(nu_r));
    nvs  = 34'($signed(nv_r));
    nts  = 34'($signed(nt_r));
    if (det_r[31]) begin
      dets = -dets; nus = -nus; nvs = -nvs; nts = -nts;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, dabs_r});

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      miss_r <= (dets <= 34'($signed({1'b0, thr_r}))) || nus < 0 || nus > dets
                || nvs < 0 || (nus + nvs) > dets || nts < 0;
      dabs_r <= dets[31:0];
      rem_r  <= '0;
      quo_r  <= {nts[31:0], {FRAC_BITS{1'b0}}};
    end else if (cmd.div_step) begin
      rem_r  <= ge ? 32'(rem_sh - {1'b0, dabs_r}) : rem_sh[31:0];
      quo_r  <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign sts.miss   = miss_r;
  assign sts.better = better;

  // best hit and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_dist_r <= '1;
      best_obj_r  <= '0;
      any_r       <= 1'b0;
    end else if (cmd.cmp && better) begin
      best_dist_r <= {1'b0, t_sat};
      best_obj_r  <= tag_r;
      any_r       <= 1'b1;
    end else if (cmd.emit) begin
      best_dist_r <= '1;
      best_obj_r  <= '0;
      any_r       <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tuser <= any_r;
      out_tdata <= any_r ? {1'b0, best_pt_r[2], best_pt_r[1], best_pt_r[0],
                            best_dist_r[30:0], best_obj_r} : '0;
    end
  end

endmodule

@@ hw/rtl/ray_triangle_nearest_hit_core.sv @@
// Top level of the ray/triangle nearest-hit core.
// A triangle request that fails the inside test passes through the micro-op issue, the check
// and the finish state before the next acceptance. One that passes also runs the divider and
// the compare, and a new nearest hit adds the hit-point steps. A triangle with tlast adds an
// emit state, plus any wait for a previous result still held. A single 32x32 multiplier and a
// one-bit-per-cycle divider set the time per request. in_tready is high only between
// requests. A result request (tuser = hit) follows the triangle with tlast; the next
// request is taken while that result waits.
module ray_triangle_nearest_hit_core #(
  parameter int FRAC_BITS = rtnh_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rtnh_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [31:0]                 cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, object_tag
  input  logic [319:0]                in_tdata,
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // hit_object, hit_distance, hit_point_x, hit_point_y, hit_point_z, pad
  output logic [159:0]                out_tdata,
  // hit
  output logic                        out_tuser
);

  localparam int NUM_W = 32 + FRAC_BITS;

  rtnh_pkg::cmd_t cmd;
  rtnh_pkg::sts_t sts;

  rtnh_ctrl #(.NUM_W(NUM_W)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tlast,
    .out_tvalid, .out_tready, .sts, .cmd
  );

  rtnh_dp #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata, .in_tdata,
    .cmd, .sts, .out_tdata, .out_tuser
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("no-hit result carries data");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("not idle after reset");

endmodule

@@ dv/rtnh_checker.sv @@
// Checker for the ray/triangle nearest-hit core: predicts pick results and compares them.
`timescale 1ns / 1ps
module rtnh_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [319:0] in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [159:0] out_tdata,
  input  logic         out_tuser,
  output int           errors,
  output int           pending,
  output int           picks_done,
  output int           hits_seen
);

  typedef struct {
    logic        hit;
    logic [31:0] obj;
    logic [30:0] distance;
    logic [31:0] px, py, pz;
  } pick_t;

  pick_t picks_q[$];
  logic signed [63:0] org[3], dir[3];
  logic [15:0] thr;
  logic [31:0] best_t;
  logic [31:0] best_obj;
  logic        best_any;
  logic signed [63:0] best_pt[3];

  assign pending = picks_q.size();

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [127:0] p;
    p = a * b;
    return 64'(p >>> rtnh_pkg::FRAC_BITS_DEF);
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic clear_best();
    best_t = '1; best_obj = '0; best_any = 1'b0;
    for (int i = 0; i < 3; i++) best_pt[i] = 0;
  endtask

  task automatic test_triangle(input logic [319:0] td, input logic lst);
    logic signed [63:0] v0[3], v1[3], v2[3], e1[3], e2[3], p[3], tv[3], q[3];
    logic signed [63:0] det, nu, nv, nt, mag;
    logic [63:0] t;
    pick_t r;
    for (int i = 0; i < 3; i++) begin
      v0[i] = $signed(td[32*i +: 32]);
      v1[i] = $signed(td[32*(3+i) +: 32]);
      v2[i] = $signed(td[32*(6+i) +: 32]);
    end
    for (int i = 0; i < 3; i++) begin
      e1[i] = clamp32(v1[i] - v0[i]);
      e2[i] = clamp32(v2[i] - v0[i]);
      tv[i] = clamp32(org[i] - v0[i]);
    end
    p[0] = clamp32(qmul(dir[1], e2[2]) - qmul(dir[2], e2[1]));
    p[1] = clamp32(qmul(dir[2], e2[0]) - qmul(dir[0], e2[2]));
    p[2] = clamp32(qmul(dir[0], e2[1]) - qmul(dir[1], e2[0]));
    det = clamp32(qmul(e1[0], p[0]) + qmul(e1[1], p[1]) + qmul(e1[2], p[2]));
    mag = det < 0 ? -det : det;
    if (mag > $signed({48'd0, thr})) begin
      nu = clamp32(qmul(tv[0], p[0]) + qmul(tv[1], p[1]) + qmul(tv[2], p[2]));
      q[0] = clamp32(qmul(tv[1], e1[2]) - qmul(tv[2], e1[1]));
      q[1] = clamp32(qmul(tv[2], e1[0]) - qmul(tv[0], e1[2]));
      q[2] = clamp32(qmul(tv[0], e1[1]) - qmul(tv[1], e1[0]));
      nv = clamp32(qmul(dir[0], q[0]) + qmul(dir[1], q[1]) + qmul(dir[2], q[2]));
      nt = clamp32(qmul(e2[0], q[0]) + qmul(e2[1], q[1]) + qmul(e2[2], q[2]));
      if (det < 0) begin
        det = -det; nu = -nu; nv = -nv; nt = -nt;
      end
      if (!(nu < 0 || nu > det || nv < 0 || nu + nv > det || nt < 0)) begin
        t = (64'(nt) << rtnh_pkg::FRAC_BITS_DEF) / 64'(det);
        if (t > 64'h7FFF_FFFF) t = 64'h7FFF_FFFF;
        if (t < {32'd0, best_t}) begin
          best_t = t[31:0];
          best_obj = td[288 +: 32];
          best_any = 1'b1;
          for (int i = 0; i < 3; i++)
            best_pt[i] = clamp32(org[i] + qmul(dir[i], $signed(t)));
        end
      end
    end
    if (lst) begin
      r.hit = best_any;
      r.obj = best_any ? best_obj : '0;
      r.distance = best_any ? best_t[30:0] : '0;
      r.px = best_any ? best_pt[0][31:0] : '0;
      r.py = best_any ? best_pt[1][31:0] : '0;
      r.pz = best_any ? best_pt[2][31:0] : '0;
      picks_q.push_back(r);
      clear_best();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      org[0] = 0; org[1] = 0; org[2] = 0;
      dir[0] = 65536; dir[1] = 0; dir[2] = 0;
      thr = 16'd1;
      clear_best();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          rtnh_pkg::CFG_ORIGIN_X: org[0] = $signed(cfg_wdata);
          rtnh_pkg::CFG_ORIGIN_Y: org[1] = $signed(cfg_wdata);
          rtnh_pkg::CFG_ORIGIN_Z: org[2] = $signed(cfg_wdata);
          rtnh_pkg::CFG_DIR_X:    dir[0] = $signed(cfg_wdata);
          rtnh_pkg::CFG_DIR_Y:    dir[1] = $signed(cfg_wdata);
          rtnh_pkg::CFG_DIR_Z:    dir[2] = $signed(cfg_wdata);
          rtnh_pkg::CFG_DET_THR:  thr = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (picks_q.size() == 0) begin
          report("unexpected result", 64'(out_tuser), 64'd0);
        end else begin
          pick_t w;
          w = picks_q.pop_front();
          picks_done++;
          if (w.hit) hits_seen++;
          if (out_tuser !== w.hit) report("hit", 64'(out_tuser), 64'(w.hit));
          if (out_tdata[31:0] !== w.obj) report("object", out_tdata[31:0], w.obj);
          if (out_tdata[62:32] !== w.distance)
            report("distance", out_tdata[62:32], w.distance);
          if (out_tdata[94:63] !== w.px) report("point_x", out_tdata[94:63], w.px);
          if (out_tdata[126:95] !== w.py) report("point_y", out_tdata[126:95], w.py);
          if (out_tdata[158:127] !== w.pz) report("point_z", out_tdata[158:127], w.pz);
        end
      end
      if (in_tvalid && in_tready) test_triangle(in_tdata, in_tlast);
    end
  end

  initial begin
    errors = 0; picks_done = 0; hits_seen = 0;
  end
endmodule

@@ dv/tb_top.sv @@
// Testbench top: drives triangle picks and ray settings into the nearest-hit core.
`timescale 1ns / 1ps
module tb_top;

  localparam int STALL_LIMIT = 20000;

  logic clk, rst_n;
  logic cfg_we;
  logic [rtnh_pkg::CFG_AW-1:0] cfg_addr;
  logic [31:0] cfg_wdata;
  logic in_tvalid, in_tready, in_tlast;
  logic [319:0] in_tdata;
  logic out_tvalid, out_tready, out_tuser;
  logic [159:0] out_tdata;
  int errors, pending, picks_done, hits_seen;
  int idle_cycles, sent;
  logic calm;

  ray_triangle_nearest_hit_core uut (.*);

  rtnh_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side backpressure
  initial begin
    int n;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 14);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [rtnh_pkg::CFG_AW-1:0] a, input logic [31:0] d);
    cfg_we <= 1'b1; cfg_addr <= a; cfg_wdata <= d;
    @(posedge clk);
  endtask

  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_ray(input logic [31:0] ox, oy, oz, dx, dy, dz, input logic [15:0] th);
    write_reg(rtnh_pkg::CFG_ORIGIN_X, ox);
    write_reg(rtnh_pkg::CFG_ORIGIN_Y, oy);
    write_reg(rtnh_pkg::CFG_ORIGIN_Z, oz);
    write_reg(rtnh_pkg::CFG_DIR_X, dx);
    write_reg(rtnh_pkg::CFG_DIR_Y, dy);
    write_reg(rtnh_pkg::CFG_DIR_Z, dz);
    write_reg(rtnh_pkg::CFG_DET_THR, {16'd0, th});
    cfg_we <= 1'b0;
  endtask

  task automatic send_tri(input logic [319:0] d, input logic lst);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1; in_tdata <= d; in_tlast <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [31:0] coord(input int span);
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  // triangle straddling the x axis in a plane x = px, random winding
  function automatic logic [319:0] facing_tri(input int px, input logic [31:0] tag);
    logic [31:0] a, b;
    int s;
    s = $urandom_range(1, 8) << 16;
    a = 32'(-$signed($urandom_range(0, s)));
    b = 32'($urandom_range(0, s));
    if ($urandom_range(0, 1))
      return {tag, a, 32'(s), 32'(px), 32'(-s), b, 32'(px), b, a, 32'(px)};
    return {tag, 32'(-s), b, 32'(px), a, 32'(s), 32'(px), b, a, 32'(px)};
  endfunction

  function automatic logic [319:0] noise_tri();
    logic [319:0] d;
    for (int i = 0; i < 9; i++) d[32*i +: 32] = coord(20 << 16);
    d[288 +: 32] = $urandom();
    return d;
  endfunction

  initial begin
    logic [319:0] t;
    int n;
    calm = 1'b0; sent = 0; idle_cycles = 0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    in_tvalid = 1'b0; in_tdata = '0; in_tlast = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default ray along +x
    send_tri(facing_tri(5 << 16, 32'hFFFF_FFFF), 1'b1);
    send_tri(facing_tri(-(5 << 16), 32'h1), 1'b1);            // behind origin
    send_tri({32'h2, {3{32'(1 << 16), 32'd0, 32'd0}}}, 1'b1); // degenerate, parallel
    send_tri(facing_tri(3 << 16, 32'hA), 1'b0);               // equal distance tie
    send_tri(facing_tri(3 << 16, 32'hB), 1'b0);
    send_tri(facing_tri(7 << 16, 32'hC), 1'b1);
    t = {32'h0, {9{32'h7FFF_FFFF}}}; send_tri(t, 1'b0);
    t = {32'h0, {9{32'h8000_0000}}}; send_tri(t, 1'b0);
    send_tri({32'h5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b1);
    send_tri(facing_tri(32'h7FFF_0000, 32'h6), 1'b1);         // far away, saturating
    send_tri({32'h7, 32'd0, 32'd0, 32'(1 << 16), 32'd0, 32'(1 << 16), 32'd0,
              32'd0, 32'd0, 32'd0}, 1'b1);                    // edge of triangle
    quiesce();

    set_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_tri(noise_tri(), i == 3);
    send_tri(facing_tri(2 << 16, 32'h9), 1'b1);
    quiesce();
    set_ray(32'd0, 32'd0, 32'd0, 32'(1 << 16), 32'd0, 32'd0, 16'd0);
    send_tri(facing_tri(4 << 16, 32'h11), 1'b1);
    quiesce();

    // random picks under several rays
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) calm = 1'b1;
      case (ph % 3)
        0: set_ray(32'($signed($urandom_range(0, 4 << 16)) - (2 << 16)), 32'd0, 32'd0,
                   32'($urandom_range(1 << 14, 4 << 16)), 32'($urandom_range(0, 1 << 12)),
                   32'($urandom_range(0, 1 << 12)), 16'($urandom_range(0, 16)));
        1: set_ray(32'($urandom_range(0, 1 << 16)), 32'($urandom_range(0, 1 << 14)),
                   32'($urandom_range(0, 1 << 14)), 32'(1 << 16), 32'd0, 32'd0,
                   16'($urandom()));
        default: set_ray($urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom(), 16'($urandom()));
      endcase
      for (int k = 0; k < 70; k += n) begin
        n = $urandom_range(1, 6);
        for (int j = 0; j < n; j++) begin
          if ($urandom_range(0, 3) == 0) t = noise_tri();
          else t = facing_tri($urandom_range(1, 60) << 12, $urandom());
          send_tri(t, j == n - 1);
        end
      end
      quiesce();
    end

    fork
      quiesce();
      begin
        repeat (STALL_LIMIT) @(posedge clk);
      end
    join_any
    disable fork;
    $display("Sent %0d triangles in %0d picks, %0d of them hits, over several ray settings.",
             sent, picks_done, hits_seen);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/rtnh_pkg.sv
hw/rtl/rtnh_ctrl.sv
hw/rtl/rtnh_dp.sv
hw/rtl/ray_triangle_nearest_hit_core.sv
dv/rtnh_checker.sv
dv/tb_top.sv
